>>> rtl/core/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg: shared types and constants for the sustained level alarm
// Holds the payload structs, the register map, the alarm phase codes and
// the constants of the reciprocal divide used by the sensor lanes.
// ----------------------------------------------------------------------------
package sla_pkg;

  // window and sample geometry
  localparam int unsigned WINDOW      = 100;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned WIN_CLOG  = $clog2(WINDOW);
  localparam int unsigned CNT_W     = (WINDOW > 1) ? WIN_CLOG : 1;
  localparam int unsigned SUM_W     = SAMPLE_BITS + WIN_CLOG;

  // exact divide by WINDOW for any sum below 2**SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + WIN_CLOG;
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned QUOT_W    = PROD_W - DIV_SHIFT;
  localparam longint unsigned RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = '1;
  localparam logic [TIMER_W-1:0]  LOUD_MAX    = '1;
  localparam logic [CNT_W-1:0]    CNT_LAST    = CNT_W'(WINDOW - 1);

  // register map, word index
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_WARN  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;
  localparam logic [1:0] REG_ALERT = 2'd3;

  localparam logic [LEVEL_W-1:0] WARN_RST  = 10'd500;
  localparam logic [LEVEL_W-1:0] LIMIT_RST = 10'd500;
  localparam logic [TIMER_W-1:0] TOL_RST   = 16'd2000;
  localparam logic [TIMER_W-1:0] ALERT_RST = 16'd3000;

  // alarm phase codes
  localparam logic [1:0] PH_MEASURE = 2'd0;
  localparam logic [1:0] PH_LIGHT   = 2'd1;
  localparam logic [1:0] PH_BOTH    = 2'd2;
  localparam logic [1:0] PH_SILENT  = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_req_t;

  typedef struct packed {
    logic               light_on;
    logic               sound_on;
    logic [LEVEL_W-1:0] level;
    logic               level_valid;
  } out_rsp_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] warn_level;
    logic [LEVEL_W-1:0] limit_level;
    logic [TIMER_W-1:0] tolerance_ms;
    logic [TIMER_W-1:0] alert_ms;
  } cfg_t;

  // lane control from the merge stage
  typedef struct packed {
    logic add;
    logic close;
  } lane_ctl_t;

endpackage

>>> rtl/core/sla_lane.sv
// ----------------------------------------------------------------------------
// sla_lane: window accumulator and average for one sensor
// Sums the masked samples of one sensor, snapshots the sum when the window
// closes and divides it by the window length with a reciprocal multiply.
// ----------------------------------------------------------------------------
module sla_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sla_pkg::lane_ctl_t         ctl_i,
  input  logic [sla_pkg::SAMPLE_W-1:0] sample_i,
  output logic [sla_pkg::LEVEL_W-1:0]  avg_o
);
  import sla_pkg::*;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  div_sum_q;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  sum_next;
  logic [QUOT_W-1:0] quot;

  assign sum_next = sum_q + SUM_W'(sample_i & SAMPLE_MASK);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.close) begin
      sum_d = '0;
    end else if (ctl_i.add) begin
      sum_d = sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // snapshot and product hold while the merge stage waits
  always_ff @(posedge clk_i) begin
    if (ctl_i.close) begin
      div_sum_q <= sum_next;
    end
    prod_q <= PROD_W'(div_sum_q) * PROD_W'(RECIP);
  end

  assign quot  = prod_q[PROD_W-1:DIV_SHIFT];
  assign avg_o = (32'(quot) > 32'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(quot);

endmodule

>>> rtl/core/sla_ctrl.sv
// ----------------------------------------------------------------------------
// sla_ctrl: merge stage and alarm sequencer
// Steers the lanes, merges their averages into the level, keeps the loud
// count and the alert phases, and holds the result register.
// ----------------------------------------------------------------------------
module sla_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sla_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  output sla_pkg::lane_ctl_t          lane_ctl_o,
  input  logic [sla_pkg::LEVEL_W-1:0] avg_a_i,
  input  logic [sla_pkg::LEVEL_W-1:0] avg_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sla_pkg::out_rsp_t           out_rsp_o
);
  import sla_pkg::*;

  logic [1:0]         phase_q, phase_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [TIMER_W-1:0] loud_q, loud_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [LEVEL_W-1:0] last_level_q, last_level_d;
  logic               s1_q, s1_d;
  logic               s2_q, s2_d;
  logic               out_valid_q, out_valid_d;
  out_rsp_t           rsp_q, rsp_d;

  logic               out_free;
  logic               in_fire;
  logic               merge_fire;
  logic               measuring;
  logic               close;
  logic [TIMER_W-1:0] loud_inc;
  logic [TIMER_W-1:0] timer_dec;
  logic [TIMER_W-1:0] loud_merged;
  logic [LEVEL_W-1:0] lvl;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_q || s2_q || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign merge_fire = s2_q && out_free;
  assign measuring  = (phase_q == PH_MEASURE);
  assign close      = in_fire && measuring && (count_q == CNT_LAST);

  assign lane_ctl_o.close = close;
  assign lane_ctl_o.add   = in_fire && measuring && !close;

  assign loud_inc    = (loud_q == LOUD_MAX) ? loud_q : loud_q + 1'b1;
  assign timer_dec   = (timer_q == '0) ? timer_q : timer_q - 1'b1;
  assign lvl         = (avg_a_i > avg_b_i) ? avg_a_i : avg_b_i;
  assign loud_merged = (lvl < cfg_i.warn_level) ? '0 : loud_q;

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    loud_d       = loud_q;
    count_d      = count_q;
    last_level_d = last_level_q;
    rsp_d        = rsp_q;
    out_valid_d  = out_valid_q && out_stall_i;
    s1_d         = close;
    s2_d         = s1_q || (s2_q && !merge_fire);

    if (in_fire) begin
      loud_d = loud_inc;
      if (measuring) begin
        count_d = close ? '0 : count_q + 1'b1;
        if (!close) begin
          rsp_d       = '{light_on: 1'b0, sound_on: 1'b0,
                          level: last_level_q, level_valid: 1'b0};
          out_valid_d = 1'b1;
        end
      end else begin
        rsp_d       = '{light_on: (phase_q == PH_LIGHT) || (phase_q == PH_BOTH),
                        sound_on: (phase_q == PH_BOTH),
                        level: last_level_q, level_valid: 1'b0};
        out_valid_d = 1'b1;
        timer_d     = timer_dec;
        if (timer_dec == '0) begin
          if ((phase_q == PH_BOTH) && (cfg_i.alert_ms != '0)) begin
            phase_d = PH_SILENT;
            timer_d = cfg_i.alert_ms;
          end else begin
            phase_d = PH_MEASURE;
          end
        end
      end
    end

    if (merge_fire) begin
      last_level_d = lvl;
      loud_d       = loud_merged;
      if ((loud_merged > cfg_i.tolerance_ms) && (cfg_i.alert_ms != '0)) begin
        phase_d = (lvl < cfg_i.limit_level) ? PH_LIGHT : PH_BOTH;
        timer_d = cfg_i.alert_ms;
      end
      rsp_d       = '{light_on: 1'b0, sound_on: 1'b0, level: lvl, level_valid: 1'b1};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MEASURE;
      timer_q      <= '0;
      loud_q       <= '0;
      count_q      <= '0;
      last_level_q <= '0;
      s1_q         <= 1'b0;
      s2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      loud_q       <= loud_d;
      count_q      <= count_d;
      last_level_q <= last_level_d;
      s1_q         <= s1_d;
      s2_q         <= s2_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> rtl/core/sustained_level_alarm.sv
// ----------------------------------------------------------------------------
// sustained_level_alarm: two-sensor windowed level alarm
// Averages two sensors over a window in two parallel lanes, merges the
// averages into a level and runs the light / sound alert sequence.
// ----------------------------------------------------------------------------
// results: each tick's result is registered; for the tick that closes a window
//   the level goes through the lane snapshot, lane product and merge first
// throughput: one tick per cycle while the result channel is not stalled;
//   after a window-closing tick the input stalls for the lane reciprocal
//   multiply and the merge
// reset: asynchronous, active low; the control and configuration registers
//   return to their defaults and the block starts measuring with empty sums
module sustained_level_alarm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sla_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // tick request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sla_pkg::in_req_t             in_req_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sla_pkg::out_rsp_t            out_rsp_o
);
  import sla_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic               cfg_wr;
  logic [1:0]         reg_idx;
  lane_ctl_t          lane_ctl;
  logic [LEVEL_W-1:0] avg_a;
  logic [LEVEL_W-1:0] avg_b;

  // ---------------------------------------------------------------------------
  // configuration registers: writes land in the access phase, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_WARN:  cfg_d.warn_level   = pwdata[LEVEL_W-1:0];
        REG_LIMIT: cfg_d.limit_level  = pwdata[LEVEL_W-1:0];
        REG_TOL:   cfg_d.tolerance_ms = pwdata[TIMER_W-1:0];
        REG_ALERT: cfg_d.alert_ms     = pwdata[TIMER_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{warn_level: WARN_RST, limit_level: LIMIT_RST,
                 tolerance_ms: TOL_RST, alert_ms: ALERT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read data, zero-extended
  always_comb begin
    case (reg_idx)
      REG_WARN:  prdata = 32'(cfg_q.warn_level);
      REG_LIMIT: prdata = 32'(cfg_q.limit_level);
      REG_TOL:   prdata = 32'(cfg_q.tolerance_ms);
      REG_ALERT: prdata = 32'(cfg_q.alert_ms);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // one lane per sensor, both steered by the same control
  // ---------------------------------------------------------------------------
  sla_lane u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_req_i.sample_a),
    .avg_o    (avg_a)
  );

  sla_lane u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_req_i.sample_b),
    .avg_o    (avg_b)
  );

  // ---------------------------------------------------------------------------
  // merge of the lane averages, loud count, alert phases, result register
  // ---------------------------------------------------------------------------
  sla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .lane_ctl_o  (lane_ctl),
    .avg_a_i     (avg_a),
    .avg_b_i     (avg_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a closing window blocks the next request while the divide runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctl.close |=> in_stall_o)
    else $error("request taken while the window divide is in flight");

  // a lane never both adds and closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({lane_ctl.add, lane_ctl.close}))
    else $error("lane add and close together");

  // the tick that reports a new level shows no alert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.level_valid) |-> (!out_rsp_o.light_on && !out_rsp_o.sound_on))
    else $error("alert shown on a level tick");

  // sound never without light
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.sound_on) |-> out_rsp_o.light_on)
    else $error("sound without light");

endmodule
